// File: sv/lse_pkg.sv
// Shared types, constants and codes of the LIFO stack engine.
package lse_pkg;

	localparam int DEPTH  = 64;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ADDR_W = $clog2(DEPTH);

	localparam logic [2:0] CMD_PUSH    = 3'd0;
	localparam logic [2:0] CMD_POP     = 3'd1;
	localparam logic [2:0] CMD_PEEK    = 3'd2;
	localparam logic [2:0] CMD_CLEAR   = 3'd3;
	localparam logic [2:0] CMD_DISPLAY = 3'd4;

	localparam logic [2:0] ST_OK            = 3'd0;
	localparam logic [2:0] ST_OVERFLOW      = 3'd1;
	localparam logic [2:0] ST_UNDERFLOW     = 3'd2;
	localparam logic [2:0] ST_ALREADY_EMPTY = 3'd3;
	localparam logic [2:0] ST_EMPTY_DISPLAY = 3'd4;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [31:0] push_value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] data_word;
		logic [2:0]         status;
		logic               last_of_run;
		logic [6:0]         fill_count;
	} out_item_t;

	typedef struct packed {
		logic       push_wr;
		logic       pop_dec;
		logic       clear_all;
		logic       rd_top;
		logic       rd_next;
		logic       ld_status;
		logic [2:0] status;
		logic       ld_word;
		logic       last;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [2:0] command;
		logic       empty;
		logic       full;
		logic       idx_zero;
		logic       out_last;
	} dp_stat_t;

endpackage

// File: sv/lifo_stack_engine_top.sv
// Top level of the LIFO stack engine.
// Usage:
//   Input channel in_valid/in_ready/in_data carries one command beat: a command
//   code and a signed 32-bit push value. Output channel out_valid/out_ready/
//   out_data carries result beats: data word, status, last-of-run mark and the
//   fill count after the command.
//   One item is in work at a time; in_ready is high only while the engine waits.
//   Push, clear, and pop, peek or display on an empty stack: result shows in the
//   cycle after the input beat.
//   Pop and peek: the registered memory read loads the word into rdata_q, then
//   the result register takes it and shows the result beat.
//   Display of N words: N result beats, top word first; each next word is read
//   only after the previous beat is taken. The memory read port sets the pace.
//   Unused command codes are taken and dropped without a result.
//   When the receiver stalls, the result register holds its beat and no input
//   is taken. Reset clears the fill count and the controller; stored words are
//   left as they are and never read before being written.
module lifo_stack_engine_top import lse_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	lse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lse_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (out_data)
	);

endmodule

// File: sv/lse_dp.sv
// Datapath of the LIFO stack engine: word memory, fill count, read index and result register.
module lse_dp import lse_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_data,
	input  ctrl_cmd_t cmd,
	output dp_stat_t  stat,
	output out_item_t out_data
);

	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] rdata_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_d;
	logic [ADDR_W-1:0]  idx_q;
	logic [ADDR_W-1:0]  rd_addr;
	logic               rd_en;
	out_item_t          out_q;

	always_comb begin
		count_d = count_q;
		priority if (cmd.push_wr) begin
			count_d = count_q + CNT_W'(1);
		end else if (cmd.pop_dec) begin
			count_d = count_q - CNT_W'(1);
		end else if (cmd.clear_all) begin
			count_d = '0;
		end
	end

	assign rd_en   = cmd.rd_top | cmd.rd_next;
	assign rd_addr = cmd.rd_next ? (idx_q - ADDR_W'(1))
	                             : (count_q[ADDR_W-1:0] - ADDR_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_wr) begin
			mem[count_q[ADDR_W-1:0]] <= in_data.push_value;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
			idx_q   <= rd_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_status) begin
			out_q.data_word   <= '0;
			out_q.status      <= cmd.status;
			out_q.last_of_run <= 1'b1;
			out_q.fill_count  <= 7'(count_d);
		end else if (cmd.ld_word) begin
			out_q.data_word   <= rdata_q;
			out_q.status      <= ST_OK;
			out_q.last_of_run <= cmd.last;
			out_q.fill_count  <= 7'(count_q);
		end
	end

	assign stat.command  = in_data.command;
	assign stat.empty    = (count_q == '0);
	assign stat.full     = (count_q == CNT_W'(DEPTH));
	assign stat.idx_zero = (idx_q == '0);
	assign stat.out_last = out_q.last_of_run;
	assign out_data      = out_q;

endmodule

// File: sv/lse_ctrl.sv
// Controller state machine of the LIFO stack engine.
module lse_ctrl import lse_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RD   = 3'b010,
		S_OUT  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   disp_q;
	logic   disp_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_d = state_q;
		disp_d  = disp_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					disp_d = 1'b0;
					unique case (stat.command)
						CMD_PUSH: begin
							cmd.ld_status = 1'b1;
							state_d       = S_OUT;
							if (stat.full) begin
								cmd.status = ST_OVERFLOW;
							end else begin
								cmd.push_wr = 1'b1;
								cmd.status  = ST_OK;
							end
						end
						CMD_POP: begin
							if (stat.empty) begin
								cmd.ld_status = 1'b1;
								cmd.status    = ST_UNDERFLOW;
								state_d       = S_OUT;
							end else begin
								cmd.pop_dec = 1'b1;
								cmd.rd_top  = 1'b1;
								state_d     = S_RD;
							end
						end
						CMD_PEEK: begin
							if (stat.empty) begin
								cmd.ld_status = 1'b1;
								cmd.status    = ST_UNDERFLOW;
								state_d       = S_OUT;
							end else begin
								cmd.rd_top = 1'b1;
								state_d    = S_RD;
							end
						end
						CMD_CLEAR: begin
							cmd.ld_status = 1'b1;
							state_d       = S_OUT;
							if (stat.empty) begin
								cmd.status = ST_ALREADY_EMPTY;
							end else begin
								cmd.clear_all = 1'b1;
								cmd.status    = ST_OK;
							end
						end
						CMD_DISPLAY: begin
							if (stat.empty) begin
								cmd.ld_status = 1'b1;
								cmd.status    = ST_EMPTY_DISPLAY;
								state_d       = S_OUT;
							end else begin
								cmd.rd_top = 1'b1;
								disp_d     = 1'b1;
								state_d    = S_RD;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_RD: begin
				cmd.ld_word = 1'b1;
				cmd.last    = !disp_q || stat.idx_zero;
				state_d     = S_OUT;
			end
			S_OUT: begin
				if (out_ready) begin
					if (disp_q && !stat.out_last) begin
						cmd.rd_next = 1'b1;
						state_d     = S_RD;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			disp_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			disp_q  <= disp_d;
		end
	end

endmodule

// File: sv/lse_checker.sv
// Port-level checks of the LIFO stack engine and their binding to the top level.
module lse_checker import lse_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is pending");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.last_of_run)
		else $error("error status not marked last");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.fill_count <= 7'(DEPTH))
		else $error("fill count beyond depth");

	a_known_cmd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.command == CMD_PUSH || in_data.command == CMD_POP
		|| in_data.command == CMD_PEEK || in_data.command == CMD_CLEAR
		|| in_data.command == CMD_DISPLAY) |=> !in_ready)
		else $error("command accepted without producing a result");

endmodule

bind lifo_stack_engine_top lse_checker u_lse_checker (.*);

// File: test/tb_top.sv
// Testbench for the LIFO stack engine: directed and random command beats checked against a shadow stack.
module tb_top;
	import lse_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES    = 16;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	int sender_idle_pct;
	int receiver_stall_pct;
	int error_count;
	int quiet_cycles = 0;

	logic signed [31:0] shadow_words [DEPTH];
	int                 shadow_count;
	out_item_t          awaited_results [$];

	always #1 clk = ~clk;

	lifo_stack_engine_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	function automatic out_item_t result_beat(logic signed [31:0] word, logic [2:0] st,
		logic last);
		out_item_t beat;
		beat.data_word   = word;
		beat.status      = st;
		beat.last_of_run = last;
		beat.fill_count  = 7'(shadow_count);
		return beat;
	endfunction

	function automatic void apply_stack_command(in_item_t item);
		case (item.command)
			CMD_PUSH: begin
				if (shadow_count >= DEPTH) begin
					awaited_results.push_back(result_beat('0, ST_OVERFLOW, 1'b1));
				end else begin
					shadow_words[shadow_count] = item.push_value;
					shadow_count++;
					awaited_results.push_back(result_beat('0, ST_OK, 1'b1));
				end
			end
			CMD_POP: begin
				if (shadow_count == 0) begin
					awaited_results.push_back(result_beat('0, ST_UNDERFLOW, 1'b1));
				end else begin
					shadow_count--;
					awaited_results.push_back(result_beat(shadow_words[shadow_count], ST_OK, 1'b1));
				end
			end
			CMD_PEEK: begin
				if (shadow_count == 0) begin
					awaited_results.push_back(result_beat('0, ST_UNDERFLOW, 1'b1));
				end else begin
					awaited_results.push_back(result_beat(shadow_words[shadow_count - 1], ST_OK,
						1'b1));
				end
			end
			CMD_CLEAR: begin
				if (shadow_count == 0) begin
					awaited_results.push_back(result_beat('0, ST_ALREADY_EMPTY, 1'b1));
				end else begin
					shadow_count = 0;
					awaited_results.push_back(result_beat('0, ST_OK, 1'b1));
				end
			end
			CMD_DISPLAY: begin
				if (shadow_count == 0) begin
					awaited_results.push_back(result_beat('0, ST_EMPTY_DISPLAY, 1'b1));
				end else begin
					for (int k = shadow_count - 1; k >= 0; k--) begin
						awaited_results.push_back(result_beat(shadow_words[k], ST_OK, k == 0));
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", field, want, got);
			error_count++;
		end
	endfunction

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(7))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	always @(negedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$error("result beat with none expected: %p", out_data);
					error_count++;
				end else begin
					want = awaited_results.pop_front();
					compare_field("data_word", want.data_word, out_data.data_word);
					compare_field("status", 32'(want.status), 32'(out_data.status));
					compare_field("last_of_run", 32'(want.last_of_run), 32'(out_data.last_of_run));
					compare_field("fill_count", 32'(want.fill_count), 32'(out_data.fill_count));
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic send_command(logic [2:0] cmd, logic signed [31:0] value);
		in_item_t item;
		int       gap;
		item.command    = cmd;
		item.push_value = value;
		gap             = 0;
		while ($urandom_range(99) < sender_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		apply_stack_command(item);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		wait (awaited_results.size() == 0);
		@(posedge clk);
	endtask

	task automatic set_idling(int send_pct, int recv_pct);
		sender_idle_pct    = send_pct;
		receiver_stall_pct = recv_pct;
	endtask

	task automatic test_empty_stack();
		send_command(CMD_POP, rand_word());
		send_command(CMD_PEEK, rand_word());
		send_command(CMD_CLEAR, rand_word());
		send_command(CMD_DISPLAY, rand_word());
		for (int c = 5; c <= 7; c++) send_command(3'(c), rand_word());
	endtask

	task automatic test_word_extremes();
		send_command(CMD_PUSH, 32'sh8000_0000);
		send_command(CMD_PUSH, 32'sh7fff_ffff);
		send_command(CMD_PUSH, '0);
		send_command(CMD_PUSH, '1);
		send_command(CMD_PUSH, $urandom);
		send_command(CMD_PEEK, rand_word());
		send_command(CMD_DISPLAY, rand_word());
		send_command(CMD_POP, rand_word());
		send_command(CMD_PEEK, rand_word());
		repeat (4) send_command(CMD_POP, rand_word());
		send_command(CMD_POP, rand_word());
		send_command(CMD_PUSH, rand_word());
		send_command(CMD_CLEAR, rand_word());
		send_command(CMD_CLEAR, rand_word());
	endtask

	task automatic test_full_stack();
		repeat (DEPTH) send_command(CMD_PUSH, rand_word());
		send_command(CMD_PUSH, rand_word());
		send_command(CMD_PEEK, rand_word());
		send_command(CMD_DISPLAY, rand_word());
		send_command(CMD_POP, rand_word());
		send_command(CMD_PUSH, rand_word());
		send_command(CMD_PUSH, rand_word());
		send_command(CMD_CLEAR, rand_word());
	endtask

	task automatic test_random_traffic(int items);
		int pick;
		repeat (items) begin
			pick = $urandom_range(99);
			if (pick < 45)
				send_command(CMD_PUSH, rand_word());
			else if (pick < 60)
				send_command(CMD_POP, rand_word());
			else if (pick < 71)
				send_command(CMD_PEEK, rand_word());
			else if (pick < 74)
				send_command(CMD_CLEAR, rand_word());
			else if (pick < 86)
				send_command(CMD_DISPLAY, rand_word());
			else if (pick < 92)
				send_command(3'($urandom_range(5, 7)), rand_word());
			else
				send_command(CMD_PUSH, rand_word());
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		error_count  = 0;
		shadow_count = 0;
		set_idling(0, 0);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_stack();
		test_word_extremes();

		set_idling(46, 0);
		test_random_traffic(5);

		set_idling(0, 46);
		test_random_traffic(3);
		drain_results();
		test_random_traffic(2);

		set_idling(31, 31);
		test_full_stack();
		test_random_traffic(5);

		set_idling(0, 0);
		test_random_traffic(5);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (awaited_results.size() != 0) begin
			$error("%0d expected result beats never arrived", awaited_results.size());
			error_count++;
		end
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
